### rtl/core/mteq_pkg.sv
// Package with shared types, codes and constants of the timer expiry queue.
package mteq_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int MAX_OUT = 16;
    localparam int OUT_W   = $clog2(MAX_OUT + 1);

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED  = 3'd4;
    localparam logic [2:0] ST_IDLE     = 3'd5;
    localparam logic [2:0] ST_REMAIN   = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [30:0] interval_ms;
        logic [31:0] target_id;
        logic        repeat_on_expiry;
    } t_req;

    typedef struct packed {
        logic [31:0]        timer_ident;
        logic [2:0]         status;
        logic signed [31:0] remaining_ms;
        logic               last_of_run;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture request, clear scan state
        logic scan;     // evaluate slot at scan index
        logic commit;   // apply result of scan, emit transaction
        logic last;     // emitted transaction ends the run
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic       scan_done;
        logic       found;
        logic       more_due;   // scan saw more than one due timer
        logic [1:0] req_type;
    } t_sts;

endpackage

### rtl/core/mteq_datapath.sv
// Datapath of the timer expiry queue: slot store, scan unit and result register.
module mteq_datapath
    import mteq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_strobe,
    output t_rsp o_rsp
);

    logic [SLOTS-1:0] r_valid, n_valid;
    logic [31:0]      r_ident  [SLOTS];
    logic [31:0]      r_dead   [SLOTS];
    logic [30:0]      r_period [SLOTS];
    logic             r_rep    [SLOTS];
    logic [31:0]      r_counter, n_counter;

    t_req             r_req;
    logic [CNT_W-1:0] r_idx;
    logic             r_found;
    logic             r_more;
    logic [SLOT_W-1:0] r_best;
    logic signed [31:0] r_best_d;
    logic [31:0]      r_best_id;
    logic             r_strobe;
    t_rsp             r_rsp;

    logic [SLOT_W-1:0]  s_i;
    logic signed [31:0] s_d;
    logic               s_due;
    logic               s_take;
    logic [30:0]        s_ivl;

    assign s_i   = r_idx[SLOT_W-1:0];
    assign s_d   = $signed(r_dead[s_i] - r_req.now_ms);
    assign s_due = r_valid[s_i] && (s_d <= 0);
    assign s_ivl = (r_req.interval_ms == '0) ? 31'd1 : r_req.interval_ms;

    // Pick the candidate at the scan index for the current request.
    always_comb begin
        s_take = 1'b0;
        case (r_req.req_type)
            REQ_ADD:    s_take = !r_valid[s_i] && !r_found;
            REQ_REMOVE: s_take = r_valid[s_i] && !r_found
                                 && (r_ident[s_i] == r_req.target_id);
            REQ_TICK:   s_take = s_due && (!r_found
                                 || s_d < r_best_d
                                 || (s_d == r_best_d && r_ident[s_i] < r_best_id));
            default:    s_take = r_valid[s_i] && (!r_found || s_d < r_best_d);
        endcase
    end

    // Scan state and request capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_more  <= 1'b0;
        end else if (i_cmd.load || i_cmd.commit) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_more  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (s_take) r_found <= 1'b1;
            // Flag a second due timer so the run knows another result follows
            if (r_req.req_type == REQ_TICK && s_due && r_found) r_more <= 1'b1;
        end
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.scan && s_take) begin
            r_best    <= s_i;
            r_best_d  <= s_d;
            r_best_id <= r_ident[s_i];
        end
    end

    // Next slot validity and id counter.
    always_comb begin
        n_valid   = r_valid;
        n_counter = r_counter;
        if (i_cmd.commit && r_found) begin
            case (r_req.req_type)
                REQ_ADD: begin
                    n_valid[r_best] = 1'b1;
                    n_counter       = r_counter + 32'd1;
                end
                REQ_REMOVE: n_valid[r_best] = 1'b0;
                REQ_TICK:   if (!r_rep[r_best]) n_valid[r_best] = 1'b0;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_counter <= n_counter;
            r_strobe  <= i_cmd.commit;
        end
    end

    // Write slot payload on add and re-arm.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_found) begin
            if (r_req.req_type == REQ_ADD) begin
                r_ident[r_best]  <= r_counter + 32'd1;
                r_dead[r_best]   <= r_req.now_ms + {1'b0, s_ivl};
                r_period[r_best] <= s_ivl;
                r_rep[r_best]    <= r_req.repeat_on_expiry;
            end else if (r_req.req_type == REQ_TICK && r_rep[r_best]) begin
                r_dead[r_best] <= r_req.now_ms + {1'b0, r_period[r_best]};
            end
        end
    end

    // Form the result transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.last_of_run  <= i_cmd.last;
            r_rsp.remaining_ms <= '0;
            r_rsp.timer_ident  <= '0;
            case (r_req.req_type)
                REQ_ADD: begin
                    r_rsp.status <= r_found ? ST_ADDED : ST_FULL;
                    if (r_found) r_rsp.timer_ident <= r_counter + 32'd1;
                end
                REQ_REMOVE: begin
                    r_rsp.status <= r_found ? ST_REMOVED : ST_NOTFOUND;
                    if (r_found) r_rsp.timer_ident <= r_req.target_id;
                end
                REQ_TICK: begin
                    r_rsp.status <= r_found ? ST_EXPIRED : ST_IDLE;
                    if (r_found) r_rsp.timer_ident <= r_best_id;
                end
                default: begin
                    r_rsp.status <= ST_REMAIN;
                    if (!r_found)          r_rsp.remaining_ms <= -32'sd1;
                    else if (r_best_d > 0) r_rsp.remaining_ms <= r_best_d;
                end
            endcase
        end
    end

    assign o_sts.scan_done = (r_idx == CNT_W'(SLOTS));
    assign o_sts.found     = r_found;
    assign o_sts.more_due  = r_more;
    assign o_sts.req_type  = r_req.req_type;
    assign o_strobe        = r_strobe;
    assign o_rsp           = r_rsp;

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found && r_req.req_type == REQ_ADD)
        |=> (r_counter == $past(r_counter) + 32'd1))
        else $error("id counter did not advance on add");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_W'(SLOTS))
        else $error("scan index out of range");
    a_add_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found && r_req.req_type == REQ_ADD)
        |=> ($countones(r_valid) == $countones($past(r_valid)) + 1))
        else $error("add did not occupy a slot");

endmodule

### rtl/core/mteq_ctrl.sv
// Controller state machine of the timer expiry queue.
module mteq_ctrl
    import mteq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_GAP    = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [OUT_W-1:0] r_nout, n_nout;
    logic             s_tick_more;

    // A tick keeps going while another due timer remains and the run is not full.
    assign s_tick_more = (i_sts.req_type == REQ_TICK) && i_sts.found && i_sts.more_due
                         && (r_nout != OUT_W'(MAX_OUT - 1));

    always_comb begin
        n_state = r_state;
        n_nout  = r_nout;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_nout     = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_COMMIT;
                else o_cmd.scan = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                o_cmd.last   = !s_tick_more;
                if (s_tick_more) begin
                    n_nout  = r_nout + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_GAP;
                end
            end
            S_GAP:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nout  <= '0;
        end else begin
            r_state <= n_state;
            r_nout  <= n_nout;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit)
        else $error("back-to-back commit");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nout < OUT_W'(MAX_OUT))
        else $error("run exceeds result limit");

endmodule

### rtl/core/multi_timer_expiry_queue.sv
// Top level of the timer expiry queue: controller plus datapath.
// Raise start with a request while busy is low. Each request scans all
// SLOTS slots, one per cycle, then emits one result. A tick repeats the scan
// for each expired timer: a tick gives n results (n at most 16, one idle
// result when nothing is due). Results appear for one cycle with o_valid
// and cannot be stalled; o_rsp.last_of_run marks the final result of a
// request.
module multi_timer_expiry_queue
    import mteq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_cmd s_cmd;
    t_sts s_sts;

    mteq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd),
        .o_busy  (busy)
    );

    mteq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (s_cmd),
        .o_sts    (s_sts),
        .o_strobe (o_valid),
        .o_rsp    (o_rsp)
    );

endmodule
